>>> rtl/interfacial_area_correlation_top_macros.svh
// Assertion macros shared by the interfacial area correlation checker.
// No dependencies; included by the checker file.
`ifndef INTERFACIAL_AREA_CORRELATION_TOP_MACROS_SVH
`define INTERFACIAL_AREA_CORRELATION_TOP_MACROS_SVH

// Same-cycle implication, off during reset
`define IAC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define IAC_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/iac_pkg.sv
// Shared types and constants of the interfacial area correlation block.
// No dependencies; used by the top level, its checker and the testbench.
`default_nettype none

package iac_pkg;

  // Port widths
  localparam int IN_W        = 17;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Width of a Q16.16 term before the multiply by the fraction sum
  localparam int TERM_W = 37;

  // pi in Q2.30
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  // Flow regime codes
  typedef enum logic [1:0] {
    REG_BUBBLY  = 2'd0,
    REG_BLEND   = 2'd1,
    REG_ANNULAR = 2'd2
  } regime_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAS_IS_DISPERSED = 3'd0,
    CFG_LOW_COEF         = 3'd1,
    CFG_HIGH_COEF        = 3'd2,
    CFG_GEOMETRY_FACTOR  = 3'd3,
    CFG_CUTOFF_FRACTION  = 3'd4,
    CFG_FLOOR_AREA       = 3'd5
  } cfg_idx_t;

endpackage

`default_nettype wire

>>> rtl/interfacial_area_correlation_top.sv
// Interfacial area correlation for a pin lattice, one cell per transfer.
// Each cell's two phase fractions go in on the input stream; the area density
// (Q16.16, 1/m) comes out with its regime, a zero-sum flag and a saturation
// flag. The block takes one cell every clock while its skid slot is free.
// Here F is FRACTION_BITS and R = max(F+1, 21). Most of the pipe is three
// bit-per-stage units in series: the gas-fraction divider (F+1 stages), the
// twin square-root pipes (R stages) and the blend and taper divider (37
// stages). Configuration registers are written over the cfg_ port, which is
// always ready; write them only while no cell is in flight.
// Depends on iac_pkg.
`default_nettype none

module interfacial_area_correlation_top #(
  parameter int FRACTION_BITS = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // dispersed_fraction [16:0], continuous_fraction [33:17]
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [iac_pkg::IN_TDATA_W-1:0]       in_tdata,
  // interfacial_area [31:0]
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [iac_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // regime [1:0], zero_sum [2], saturated [3]
  output logic [iac_pkg::OUT_TUSER_W-1:0]      out_tuser,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [iac_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [iac_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import iac_pkg::*;

  localparam int F      = FRACTION_BITS;
  localparam int AW     = F + 1;
  localparam int SUM_W  = IN_W + 1;
  localparam int NA_W   = F + IN_W;
  localparam int ROOT_W = (F + 1 > 21) ? F + 1 : 21;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int GP_W   = AW + 24;
  localparam int PP_W   = AW + 32;
  localparam int INR_W  = AW + 25;
  localparam int PW     = TERM_W + AW;
  localparam int NUM_W  = PW + 1;
  localparam int AREA_W = TERM_W + SUM_W - 16;
  localparam int MB_W   = 32 + ROOT_W;

  localparam logic [AW-1:0] ONE_A = {1'b1, {F{1'b0}}};
  localparam longint unsigned KL_V = (11 * (64'd1 << F) + 10) / 20;
  localparam longint unsigned KH_V = (13 * (64'd1 << F) + 10) / 20;
  localparam logic [AW-1:0] KNEE_LO = AW'(KL_V);
  localparam logic [AW-1:0] KNEE_HI = AW'(KH_V);
  localparam logic [AW-1:0] DEN_BL  = AW'(KH_V - KL_V);

  typedef struct packed {
    logic [NA_W-1:0]  rem;
    logic [AW-1:0]    quo;
    logic [SUM_W-1:0] sum;
    logic             zero;
  } adiv_t;

  typedef struct packed {
    logic [AW-1:0]    alpha;
    regime_t          regime;
    logic [AW-1:0]    a_bub;
    logic [AW-1:0]    a_ann;
    logic [SUM_W-1:0] sum;
    logic             zero;
  } sel_t;

  typedef struct packed {
    logic [AW-1:0]    alpha;
    regime_t          regime;
    logic [AW-1:0]    a_bub;
    logic [GP_W-1:0]  prod_g;
    logic [PP_W-1:0]  prod_pi;
    logic [SUM_W-1:0] sum;
    logic             zero;
  } prd_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rem_b;
    logic [ROOT_W-1:0] root_b;
    logic [RAD_W-1:0]  rem_a;
    logic [ROOT_W-1:0] root_a;
    logic [AW-1:0]     alpha;
    regime_t           regime;
    logic [SUM_W-1:0]  sum;
    logic              zero;
  } sqr_t;

  typedef struct packed {
    logic [TERM_W-1:0] bub;
    logic [TERM_W-1:0] ann;
    logic [AW-1:0]     alpha;
    regime_t           regime;
    logic [SUM_W-1:0]  sum;
    logic              zero;
  } trm_t;

  typedef struct packed {
    logic [PW-1:0]    p_lo;
    logic [PW-1:0]    p_hi;
    logic [AW-1:0]    den;
    regime_t          regime;
    logic [SUM_W-1:0] sum;
    logic             zero;
  } wgt_t;

  typedef struct packed {
    logic [NUM_W-1:0]  rem;
    logic [TERM_W-1:0] quo;
    logic [AW-1:0]     den;
    regime_t           regime;
    logic [SUM_W-1:0]  sum;
    logic              zero;
  } tdiv_t;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    regime_t           regime;
    logic              zero;
  } scl_t;

  typedef struct packed {
    logic    saturated;
    logic    zero_sum;
    regime_t regime;
    logic [31:0] area;
  } res_t;

  // Configuration registers
  logic        gas_is_dispersed_r;
  logic [31:0] low_coef_r;
  logic [31:0] high_coef_r;
  logic [23:0] geometry_factor_r;
  logic [15:0] cutoff_fraction_r;
  logic [31:0] floor_area_r;

  // Pipeline enable: the whole pipe moves while the skid slot is free
  logic en;

  adiv_t ad_r   [0:AW];
  logic  ad_v_r [0:AW];
  sel_t  sel_r;
  logic  sel_v_r;
  prd_t  prd_r;
  logic  prd_v_r;
  sqr_t  sq_r   [0:ROOT_W];
  logic  sq_v_r [0:ROOT_W];
  trm_t  trm_r;
  logic  trm_v_r;
  wgt_t  wgt_r;
  logic  wgt_v_r;
  tdiv_t td_r   [0:TERM_W];
  logic  td_v_r [0:TERM_W];
  scl_t  scl_r;
  logic  scl_v_r;
  res_t  fin_r, fin_nxt;
  logic  fin_v_r;
  res_t  out_r, skid_r;
  logic  out_v_r, skid_v_r;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gas_is_dispersed_r <= 1'b1;
      low_coef_r         <= '0;
      high_coef_r        <= '0;
      geometry_factor_r  <= 24'd326895;
      cutoff_fraction_r  <= 16'd62718;
      floor_area_r       <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GAS_IS_DISPERSED: gas_is_dispersed_r <= cfg_data[0];
        CFG_LOW_COEF:         low_coef_r         <= cfg_data;
        CFG_HIGH_COEF:        high_coef_r        <= cfg_data;
        CFG_GEOMETRY_FACTOR:  geometry_factor_r  <= cfg_data[23:0];
        CFG_CUTOFF_FRACTION:  cutoff_fraction_r  <= cfg_data[15:0];
        CFG_FLOOR_AREA:       floor_area_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en        = !skid_v_r;
  assign in_tready = en;

  // Capture: form the sum and pick the gas phase
  logic [IN_W-1:0]  disp_in, cont_in, gas_in;
  logic [SUM_W-1:0] sum_in;
  assign disp_in = in_tdata[IN_W-1:0];
  assign cont_in = in_tdata[2*IN_W-1:IN_W];
  assign sum_in  = SUM_W'(disp_in) + SUM_W'(cont_in);
  assign gas_in  = gas_is_dispersed_r ? disp_in : cont_in;

  always_ff @(posedge clk) begin
    if (!rst_n) ad_v_r[0] <= 1'b0;
    else if (en) ad_v_r[0] <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ad_r[0].rem  <= NA_W'(gas_in) << F;
      ad_r[0].quo  <= '0;
      ad_r[0].sum  <= sum_in;
      ad_r[0].zero <= (sum_in == '0);
    end
  end

  // Gas fraction divider: one quotient bit per stage, top bit first
  for (genvar k = 1; k <= AW; k++) begin : g_adiv
    localparam int B = AW - k;
    logic [NA_W:0] trial;
    adiv_t         st_nxt;

    always_comb begin
      st_nxt = ad_r[k-1];
      trial  = (NA_W + 1)'(ad_r[k-1].sum) << B;
      if ({1'b0, ad_r[k-1].rem} >= trial) begin
        st_nxt.rem    = NA_W'({1'b0, ad_r[k-1].rem} - trial);
        st_nxt.quo[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) ad_v_r[k] <= 1'b0;
      else if (en) ad_v_r[k] <= ad_v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) ad_r[k] <= st_nxt;
    end
  end

  // Regime select; the blend runs both terms at the knees
  sel_t sel_nxt;
  always_comb begin
    sel_nxt.alpha = ad_r[AW].quo;
    sel_nxt.sum   = ad_r[AW].sum;
    sel_nxt.zero  = ad_r[AW].zero;
    if (ad_r[AW].quo < KNEE_LO) sel_nxt.regime = REG_BUBBLY;
    else if (ad_r[AW].quo >= KNEE_HI) sel_nxt.regime = REG_ANNULAR;
    else sel_nxt.regime = REG_BLEND;
    sel_nxt.a_bub = (sel_nxt.regime == REG_BLEND) ? KNEE_LO : ad_r[AW].quo;
    sel_nxt.a_ann = (sel_nxt.regime == REG_BLEND) ? KNEE_HI : ad_r[AW].quo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sel_v_r <= 1'b0;
    else if (en) sel_v_r <= ad_v_r[AW];
  end

  always_ff @(posedge clk) begin
    if (en) sel_r <= sel_nxt;
  end

  // Annular radicand products
  always_ff @(posedge clk) begin
    if (!rst_n) prd_v_r <= 1'b0;
    else if (en) prd_v_r <= sel_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prd_r.alpha   <= sel_r.alpha;
      prd_r.regime  <= sel_r.regime;
      prd_r.a_bub   <= sel_r.a_bub;
      prd_r.prod_g  <= GP_W'(ONE_A - sel_r.a_ann) * GP_W'(geometry_factor_r);
      prd_r.prod_pi <= PP_W'(PI_Q30) * PP_W'(sel_r.a_ann);
      prd_r.sum     <= sel_r.sum;
      prd_r.zero    <= sel_r.zero;
    end
  end

  // Sum the radicand and move it to Q32
  logic [INR_W-1:0] inner;
  logic [RAD_W-1:0] rad_a;
  assign inner = INR_W'(prd_r.prod_g) + INR_W'(prd_r.prod_pi >> 14);

  if (F <= 16) begin : g_rad_up
    assign rad_a = RAD_W'(inner) << (16 - F);
  end else begin : g_rad_dn
    assign rad_a = RAD_W'(inner >> (F - 16));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else if (en) sq_v_r[0] <= prd_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0].rem_b  <= RAD_W'(prd_r.a_bub) << F;
      sq_r[0].root_b <= '0;
      sq_r[0].rem_a  <= rad_a;
      sq_r[0].root_a <= '0;
      sq_r[0].alpha  <= prd_r.alpha;
      sq_r[0].regime <= prd_r.regime;
      sq_r[0].sum    <= prd_r.sum;
      sq_r[0].zero   <= prd_r.zero;
    end
  end

  // Twin floor square roots, one root bit per stage
  for (genvar k = 1; k <= ROOT_W; k++) begin : g_sqrt
    localparam int B = ROOT_W - k;
    logic [RAD_W:0] trial_b, trial_a;
    sqr_t           st_nxt;

    always_comb begin
      st_nxt  = sq_r[k-1];
      trial_b = ((RAD_W + 1)'(sq_r[k-1].root_b) << (B + 1))
              | ((RAD_W + 1)'(1) << (2 * B));
      trial_a = ((RAD_W + 1)'(sq_r[k-1].root_a) << (B + 1))
              | ((RAD_W + 1)'(1) << (2 * B));
      if ({1'b0, sq_r[k-1].rem_b} >= trial_b) begin
        st_nxt.rem_b     = RAD_W'({1'b0, sq_r[k-1].rem_b} - trial_b);
        st_nxt.root_b[B] = 1'b1;
      end
      if ({1'b0, sq_r[k-1].rem_a} >= trial_a) begin
        st_nxt.rem_a     = RAD_W'({1'b0, sq_r[k-1].rem_a} - trial_a);
        st_nxt.root_a[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[k] <= 1'b0;
      else if (en) sq_v_r[k] <= sq_v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) sq_r[k] <= st_nxt;
    end
  end

  // Coefficient times root for both terms
  logic [MB_W-1:0] mul_b, mul_a;
  assign mul_b = MB_W'(low_coef_r) * MB_W'(sq_r[ROOT_W].root_b);
  assign mul_a = MB_W'(high_coef_r) * MB_W'(sq_r[ROOT_W].root_a);

  always_ff @(posedge clk) begin
    if (!rst_n) trm_v_r <= 1'b0;
    else if (en) trm_v_r <= sq_v_r[ROOT_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trm_r.bub    <= TERM_W'(mul_b >> F);
      trm_r.ann    <= TERM_W'(mul_a >> 16);
      trm_r.alpha  <= sq_r[ROOT_W].alpha;
      trm_r.regime <= sq_r[ROOT_W].regime;
      trm_r.sum    <= sq_r[ROOT_W].sum;
      trm_r.zero   <= sq_r[ROOT_W].zero;
    end
  end

  // Blend weights or taper factor, with the matching divisor
  logic [AW-1:0]     cut, den_tp, rem_a, w_lo, w_hi, den_sel;
  logic [TERM_W-1:0] x_lo, x_hi;

  if (F >= 16) begin : g_cut_up
    assign cut = AW'(cutoff_fraction_r) << (F - 16);
  end else begin : g_cut_dn
    assign cut = AW'(cutoff_fraction_r >> (16 - F));
  end
  assign den_tp = ONE_A - cut;
  assign rem_a  = ONE_A - trm_r.alpha;

  always_comb begin
    x_lo    = '0;
    w_lo    = '0;
    x_hi    = '0;
    w_hi    = '0;
    den_sel = AW'(1);
    case (trm_r.regime)
      REG_BUBBLY: begin
        x_lo = trm_r.bub;
        w_lo = AW'(1);
      end
      REG_BLEND: begin
        x_lo    = trm_r.bub;
        w_lo    = KNEE_HI - trm_r.alpha;
        x_hi    = trm_r.ann;
        w_hi    = trm_r.alpha - KNEE_LO;
        den_sel = DEN_BL;
      end
      REG_ANNULAR: begin
        x_hi = trm_r.ann;
        if (rem_a < den_tp) begin
          w_hi    = rem_a;
          den_sel = den_tp;
        end else begin
          w_hi = AW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) wgt_v_r <= 1'b0;
    else if (en) wgt_v_r <= trm_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wgt_r.p_lo   <= PW'(x_lo) * PW'(w_lo);
      wgt_r.p_hi   <= PW'(x_hi) * PW'(w_hi);
      wgt_r.den    <= den_sel;
      wgt_r.regime <= trm_r.regime;
      wgt_r.sum    <= trm_r.sum;
      wgt_r.zero   <= trm_r.zero;
    end
  end

  // Add the weighted parts into the dividend
  always_ff @(posedge clk) begin
    if (!rst_n) td_v_r[0] <= 1'b0;
    else if (en) td_v_r[0] <= wgt_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      td_r[0].rem    <= NUM_W'(wgt_r.p_lo) + NUM_W'(wgt_r.p_hi);
      td_r[0].quo    <= '0;
      td_r[0].den    <= wgt_r.den;
      td_r[0].regime <= wgt_r.regime;
      td_r[0].sum    <= wgt_r.sum;
      td_r[0].zero   <= wgt_r.zero;
    end
  end

  // Term divider: one quotient bit per stage, top bit first
  for (genvar k = 1; k <= TERM_W; k++) begin : g_tdiv
    localparam int B = TERM_W - k;
    logic [NUM_W-1:0] trial;
    tdiv_t            st_nxt;

    always_comb begin
      st_nxt = td_r[k-1];
      trial  = NUM_W'(td_r[k-1].den) << B;
      if (td_r[k-1].rem >= trial) begin
        st_nxt.rem    = td_r[k-1].rem - trial;
        st_nxt.quo[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) td_v_r[k] <= 1'b0;
      else if (en) td_v_r[k] <= td_v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) td_r[k] <= st_nxt;
    end
  end

  // Scale by the fraction sum
  logic [TERM_W+SUM_W-1:0] mul_s;
  assign mul_s = (TERM_W + SUM_W)'(td_r[TERM_W].quo) * (TERM_W + SUM_W)'(td_r[TERM_W].sum);

  always_ff @(posedge clk) begin
    if (!rst_n) scl_v_r <= 1'b0;
    else if (en) scl_v_r <= td_v_r[TERM_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      scl_r.area   <= AREA_W'(mul_s >> 16);
      scl_r.regime <= td_r[TERM_W].regime;
      scl_r.zero   <= td_r[TERM_W].zero;
    end
  end

  // Floor, saturate and force the zero-sum result
  logic [AREA_W-1:0] floored;
  always_comb begin
    floored = scl_r.area;
    if (scl_r.regime == REG_ANNULAR && scl_r.area < AREA_W'(floor_area_r)) begin
      floored = AREA_W'(floor_area_r);
    end
    fin_nxt.regime    = scl_r.regime;
    fin_nxt.zero_sum  = 1'b0;
    fin_nxt.saturated = |floored[AREA_W-1:32];
    fin_nxt.area      = fin_nxt.saturated ? '1 : floored[31:0];
    if (scl_r.zero) begin
      fin_nxt.regime    = REG_BUBBLY;
      fin_nxt.zero_sum  = 1'b1;
      fin_nxt.saturated = 1'b0;
      fin_nxt.area      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fin_v_r <= 1'b0;
    else if (en) fin_v_r <= scl_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) fin_r <= fin_nxt;
  end

  // Output register with a skid slot behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (en) begin
      if (out_v_r && !out_tready) begin
        skid_v_r <= fin_v_r;
      end else begin
        out_v_r <= fin_v_r;
      end
    end else if (out_tready) begin
      skid_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (out_v_r && !out_tready) skid_r <= fin_r;
      else out_r <= fin_r;
    end else if (out_tready) begin
      out_r <= skid_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r.area;
  assign out_tuser  = {out_r.saturated, out_r.zero_sum, out_r.regime};

endmodule

`default_nettype wire

>>> rtl/iac_checker.sv
// Port-level checks for the interfacial area correlation top level.
// Depends on iac_pkg and the assertion macro header; bound to the top level.
`default_nettype none
`include "interfacial_area_correlation_top_macros.svh"

module iac_checker (
  input wire                                 clk,
  input wire                                 rst_n,
  input wire                                 in_tready,
  input wire                                 out_tvalid,
  input wire                                 out_tready,
  input wire [iac_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input wire [iac_pkg::OUT_TUSER_W-1:0]      out_tuser
);
  import iac_pkg::*;

  // A zero-sum result carries no area, the bubbly regime and no clip
  `IAC_ASSERT_IMP(a_zero_clean, clk, rst_n, out_tvalid && out_tuser[2], out_tdata == '0 && out_tuser[1:0] == REG_BUBBLY && !out_tuser[3], "zero-sum result not cleared")

  // A clipped result sits at full scale
  `IAC_ASSERT_IMP(a_sat_full, clk, rst_n, out_tvalid && out_tuser[3], out_tdata == '1 && !out_tuser[2], "saturated result not at maximum")

  // Input backpressure only follows a stalled output transfer
  `IAC_ASSERT_IMP(a_backpressure, clk, rst_n, !in_tready, $past(out_tvalid && !out_tready), "input stalled without output stall")

  // A stalled result holds
  `IAC_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

bind interfacial_area_correlation_top iac_checker u_iac_checker (.*);

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for interfacial_area_correlation_top.
// Predicts each cell's area, regime and flags in a scoreboard class and checks
// the output stream in order under random idling; depends on iac_pkg.
`timescale 1ns / 100ps

import iac_pkg::*;

typedef struct packed {
  logic [31:0] area;
  regime_t     regime;
  logic        zero_sum;
  logic        saturated;
} area_result_t;

class area_scoreboard;
  localparam int F = 16;
  localparam logic [63:0] ONE_F = 64'd1 << F;
  localparam logic [63:0] KNEE_LO = (11 * ONE_F + 10) / 20;
  localparam logic [63:0] KNEE_HI = (13 * ONE_F + 10) / 20;

  logic        gas_disp;
  logic [31:0] low_c, high_c, floor_a;
  logic [23:0] geom;
  logic [15:0] cutoff;
  area_result_t pending[$];
  int errors;

  function new();
    gas_disp = 1; low_c = 0; high_c = 0; geom = 24'd326895;
    cutoff = 16'd62718; floor_a = 0; errors = 0;
  endfunction

  function void write_reg(cfg_idx_t idx, logic [31:0] val);
    case (idx)
      CFG_GAS_IS_DISPERSED: gas_disp = val[0];
      CFG_LOW_COEF:         low_c = val;
      CFG_HIGH_COEF:        high_c = val;
      CFG_GEOMETRY_FACTOR:  geom = val[23:0];
      CFG_CUTOFF_FRACTION:  cutoff = val[15:0];
      CFG_FLOOR_AREA:       floor_a = val;
      default: ;
    endcase
  endfunction

  // Floor integer square root, bit by bit
  function logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function logic [63:0] bubbly(logic [63:0] alpha);
    return (64'(low_c) * floor_root(alpha << F)) >> F;
  endfunction

  function logic [63:0] annular(logic [63:0] alpha);
    logic [63:0] radicand;
    radicand = (ONE_F - alpha) * 64'(geom) + ((64'(PI_Q30) * alpha) >> 14);
    return (64'(high_c) * floor_root(radicand)) >> 16;
  endfunction

  // Note an accepted cell and queue its expected result
  function void note_cell(logic [16:0] disp, logic [16:0] cont);
    logic [63:0] total, gas, alpha, term, area, rem, den;
    area_result_t r;
    total = 64'(disp) + 64'(cont);
    gas = gas_disp ? 64'(disp) : 64'(cont);
    r = '0;
    if (total == 0) begin
      r.zero_sum = 1;
      r.regime = REG_BUBBLY;
    end else begin
      alpha = (gas << F) / total;
      if (alpha < KNEE_LO) begin
        r.regime = REG_BUBBLY;
        term = bubbly(alpha);
      end else if (alpha >= KNEE_HI) begin
        r.regime = REG_ANNULAR;
        rem = ONE_F - alpha;
        den = ONE_F - 64'(cutoff);
        term = annular(alpha);
        if (den != 0 && rem < den) term = term * rem / den;
      end else begin
        r.regime = REG_BLEND;
        term = (bubbly(KNEE_LO) * (KNEE_HI - alpha) + annular(KNEE_HI) * (alpha - KNEE_LO))
               / (KNEE_HI - KNEE_LO);
      end
      area = (term * total) >> 16;
      if (r.regime == REG_ANNULAR && area < 64'(floor_a)) area = 64'(floor_a);
      if (area > 64'hFFFF_FFFF) begin
        area = 64'hFFFF_FFFF;
        r.saturated = 1;
      end
      r.area = area[31:0];
    end
    pending.push_back(r);
  endfunction

  // Compare one output transfer with the oldest expectation
  function void check_result(logic [31:0] area, logic [3:0] flags);
    area_result_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result area=%h flags=%h", $time, area, flags);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (area !== e.area) begin
      $display("%0t: area expected %h actual %h", $time, e.area, area);
      errors++;
    end
    if (flags[1:0] !== e.regime) begin
      $display("%0t: regime expected %0d actual %0d", $time, e.regime, flags[1:0]);
      errors++;
    end
    if (flags[2] !== e.zero_sum) begin
      $display("%0t: zero_sum expected %b actual %b", $time, e.zero_sum, flags[2]);
      errors++;
    end
    if (flags[3] !== e.saturated) begin
      $display("%0t: saturated expected %b actual %b", $time, e.saturated, flags[3]);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int LATENCY = 85;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk, rst_n;
  logic in_tvalid, out_tready, cfg_valid;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic in_tready, out_tvalid, cfg_ready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int send_idle_pct, recv_stall_pct;
  bit hold_off;
  int idle_cycles;
  area_scoreboard board;

  interfacial_area_correlation_top dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stall, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      out_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each output transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
  end

  // Watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offer one cell; drop valid only in idle cycles
  task automatic send_cell(logic [16:0] disp, logic [16:0] cont);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {6'd0, cont, disp};
    do @(posedge clk); while (!in_tready);
    board.note_cell(disp, cont);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [16:0] rand_frac();
    case ($urandom_range(5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(131071));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  task automatic random_cells(int count);
    logic [16:0] d, c;
    for (int i = 0; i < count; i++) begin
      d = rand_frac();
      c = rand_frac();
      // Steer a share into the blend band and the taper zone
      if ($urandom_range(3) == 0) c = 17'($urandom_range(65536)) >> 1;
      send_cell(d, c);
    end
  endtask

  task automatic load_setting(logic gd, logic [31:0] lo, logic [31:0] hi, logic [23:0] g,
                              logic [15:0] cut, logic [31:0] fl);
    write_reg(CFG_GAS_IS_DISPERSED, 32'(gd));
    write_reg(CFG_LOW_COEF, lo);
    write_reg(CFG_HIGH_COEF, hi);
    write_reg(CFG_GEOMETRY_FACTOR, 32'(g));
    write_reg(CFG_CUTOFF_FRACTION, 32'(cut));
    write_reg(CFG_FLOOR_AREA, fl);
    cfg_valid <= 0;
  endtask

  initial begin
    board = new();
    rst_n = 0; in_tvalid = 0; in_tdata = '0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed cells with realistic coefficients
    load_setting(1, 32'h0010_0000, 32'h0008_0000, 24'd326895, 16'd62718, 32'h0000_4000);
    send_cell(0, 0);
    send_cell(17'd65536, 0);
    send_cell(0, 17'd65536);
    send_cell(17'd65536, 17'd65536);
    send_cell(17'd131071, 17'd131071);
    send_cell(17'd36045, 17'd29491);
    send_cell(17'd39322, 17'd26214);
    send_cell(17'd42598, 17'd22938);
    send_cell(17'd36044, 17'd29492);
    send_cell(17'd42597, 17'd22939);
    send_cell(17'd65000, 17'd536);
    send_cell(17'd1, 17'd131071);
    send_cell(17'd131071, 17'd1);
    send_cell(17'd21845, 17'd43690);
    send_cell(17'd5, 0);
    drain();
    // Taper off and gas as continuous phase; huge coefficients saturate
    load_setting(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_cell(17'd1000, 17'd64536);
    send_cell(17'd131071, 17'd131071);
    send_cell(17'd30000, 17'd35536);
    send_cell(0, 17'd65536);
    drain();

    // Random phases across idling profiles and settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      load_setting($urandom_range(1), $urandom, $urandom, 24'($urandom), 16'($urandom),
                   ($urandom_range(1) != 0) ? $urandom : 32'd0);
      random_cells(155);
      drain();
    end

    // Long receiver hold-off while cells keep arriving, enough to fill the pipe
    load_setting(1, 32'h0000_0000, 32'h0000_0000, 24'd0, 16'd0, 32'd0);
    send_idle_pct = 0; recv_stall_pct = 10;
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      random_cells(200);
    join
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl
rtl/iac_pkg.sv
rtl/interfacial_area_correlation_top.sv
rtl/iac_checker.sv
tb/tb.sv
